FILE: rtl/core/arsl_pkg.sv
package arsl_pkg;

  // Default sizing of the range table and of addresses
  localparam int NUM_SLOTS_DEF = 64;
  localparam int ADDR_BITS_DEF = 64;

  // Fixed field widths
  localparam int SLOT_PORT_W = 6;
  localparam int ID_W        = 16;
  localparam int COUNT_W     = 7;

  // Request kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Lookup sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_DONE  = 3'b100
  } state_t;

endpackage

FILE: rtl/core/address_range_section_lookup.sv
// Write request: taken while idle; the next request may follow right after.
// Lookup request: one read of the cached slot, then one table read per search step, all
// through the registered table read port; the input reopens as the result loads.
// Reset (rst, synchronous, active high) clears the present flags, the last-hit cache,
// the entry count and the output valid flag; table contents stay undefined until written.
module address_range_section_lookup #(
  parameter int NUM_SLOTS = arsl_pkg::NUM_SLOTS_DEF,
  parameter int ADDR_BITS = arsl_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [arsl_pkg::COUNT_W-1:0]     cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [arsl_pkg::SLOT_PORT_W-1:0] slot,
  input  logic [ADDR_BITS-1:0]             range_first,
  input  logic [ADDR_BITS-1:0]             range_last,
  input  logic [arsl_pkg::ID_W-1:0]        range_id,
  input  logic                             range_present,
  input  logic [ADDR_BITS-1:0]             query_addr,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic [arsl_pkg::ID_W-1:0]        found_id,
  output logic [arsl_pkg::SLOT_PORT_W-1:0] found_slot,
  output logic [ADDR_BITS-1:0]             offset
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int WIDE_W = ((SLOT_W > arsl_pkg::COUNT_W) ? SLOT_W : arsl_pkg::COUNT_W) + 1;

  arsl_pkg::state_t state, state_next;

  // table memory and its registered read port
  logic [ADDR_BITS-1:0]      mem_first [NUM_SLOTS];
  logic [ADDR_BITS-1:0]      mem_last  [NUM_SLOTS];
  logic [arsl_pkg::ID_W-1:0] mem_id    [NUM_SLOTS];
  logic [ADDR_BITS-1:0]      rd_first;
  logic [ADDR_BITS-1:0]      rd_last;
  logic [arsl_pkg::ID_W-1:0] rd_id;
  logic                      rd_present;
  logic [SLOT_W-1:0]         rd_addr;
  logic [SLOT_W-1:0]         rd_idx;

  logic                      present [NUM_SLOTS];
  logic                      cache_valid;
  logic [SLOT_W-1:0]         cache_slot;
  logic [CNT_W-1:0]          entry_n;

  // search window [lo, hi_ex) and request context
  logic [CNT_W-1:0]          lo, lo_next;
  logic [CNT_W-1:0]          hi_ex, hi_next;
  logic                      probe_cache;
  logic                      found, found_next;
  logic [ADDR_BITS-1:0]      addr;

  logic                      in_fire;
  logic                      cfg_fire;
  logic                      mem_we;
  logic [WIDE_W-1:0]         slot_wide;
  logic [WIDE_W-1:0]         cfg_wide;
  logic [SLOT_W-1:0]         wr_idx;
  logic                      probe_hit;
  logic                      go_left;
  logic                      finish;
  logic [CNT_W:0]            mid_sum;
  logic [SLOT_W-1:0]         mid_next;
  logic                      out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == arsl_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;

  // decode the write slot; slots beyond the table are dropped
  assign slot_wide = WIDE_W'(slot);
  assign wr_idx    = slot_wide[SLOT_W-1:0];
  assign mem_we    = in_fire && (action == arsl_pkg::ACT_WRITE) &&
                     (slot_wide < WIDE_W'(NUM_SLOTS));
  assign cfg_wide  = WIDE_W'(cfg_data);

  // test the entry that the memory returned this cycle
  assign probe_hit = rd_present && (rd_first <= addr) && (addr <= rd_last);
  assign go_left   = addr < rd_first;
  assign mid_sum   = (CNT_W + 1)'(lo_next) + (CNT_W + 1)'(hi_next) - (CNT_W + 1)'(1);
  assign mid_next  = SLOT_W'(mid_sum >> 1);

  // sequence the cache probe and the search steps
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi_ex;
    found_next = found;
    finish     = 1'b0;
    rd_addr    = rd_idx;
    unique case (state)
      arsl_pkg::S_IDLE: begin
        rd_addr = cache_slot;
        if (in_fire && (action == arsl_pkg::ACT_LOOKUP)) begin
          state_next = arsl_pkg::S_PROBE;
        end
      end
      arsl_pkg::S_PROBE: begin
        if (probe_cache) begin
          lo_next = '0;
          hi_next = entry_n;
        end else if (go_left) begin
          hi_next = CNT_W'(rd_idx);
        end else begin
          lo_next = CNT_W'(rd_idx) + CNT_W'(1);
        end
        if (probe_hit && (!probe_cache || cache_valid)) begin
          finish     = 1'b1;
          found_next = 1'b1;
        end else if (lo_next >= hi_next) begin
          finish     = 1'b1;
          found_next = 1'b0;
        end
        if (finish) begin
          state_next = arsl_pkg::S_DONE;
          rd_addr    = rd_idx;
        end else begin
          rd_addr = mid_next;
        end
      end
      arsl_pkg::S_DONE: begin
        rd_addr = rd_idx;
        if (out_free) begin
          state_next = arsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = arsl_pkg::S_IDLE;
      end
    endcase
  end

  // write the table and read one entry a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_first[wr_idx] <= range_first;
      mem_last[wr_idx]  <= range_last;
      mem_id[wr_idx]    <= range_id;
    end
    rd_first   <= mem_first[rd_addr];
    rd_last    <= mem_last[rd_addr];
    rd_id      <= mem_id[rd_addr];
    rd_present <= present[rd_addr];
    rd_idx     <= rd_addr;
  end

  // hold the present flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        present[i] <= 1'b0;
      end
    end else if (mem_we) begin
      present[wr_idx] <= range_present;
    end
  end

  // advance control state, the cache and the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= arsl_pkg::S_IDLE;
      cache_valid <= 1'b0;
      cache_slot  <= '0;
      entry_n     <= '0;
      probe_cache <= 1'b0;
      found       <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
      if (cfg_fire) begin
        entry_n     <= (cfg_wide > WIDE_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : CNT_W'(cfg_wide);
        cache_valid <= 1'b0;
      end else if (mem_we) begin
        cache_valid <= 1'b0;
      end else if (finish && found_next) begin
        cache_valid <= 1'b1;
        cache_slot  <= rd_idx;
      end
      if (in_fire) begin
        probe_cache <= 1'b1;
      end else if (state == arsl_pkg::S_PROBE) begin
        probe_cache <= 1'b0;
      end
    end
  end

  // latch the looked-up address and the search window
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr <= query_addr;
    end
    lo    <= lo_next;
    hi_ex <= hi_next;
  end

  // drive the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == arsl_pkg::S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == arsl_pkg::S_DONE) && out_free) begin
      hit        <= found;
      found_id   <= found ? rd_id : '0;
      found_slot <= found ? arsl_pkg::SLOT_PORT_W'(rd_idx) : '0;
      offset     <= found ? (addr - rd_first) : '0;
    end
  end

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (found_id == '0) && (found_slot == '0) && (offset == '0))
    else $error("miss result carries nonzero fields");

  a_write_clears_cache: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !cache_valid)
    else $error("cache still valid after a table write");

  a_hit_fills_cache: assert property (@(posedge clk) disable iff (rst)
    finish && found_next |=> cache_valid && (cache_slot == $past(rd_idx)))
    else $error("lookup hit not recorded in cache");

  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == arsl_pkg::S_PROBE) && !probe_cache |->
      (CNT_W'(rd_idx) >= lo) && (CNT_W'(rd_idx) < hi_ex))
    else $error("search probe outside its window");
`endif

endmodule

FILE: dv/tb_address_range_section_lookup.sv
module tb_address_range_section_lookup;

  localparam int SLOTS       = arsl_pkg::NUM_SLOTS_DEF;
  localparam int AW          = arsl_pkg::ADDR_BITS_DEF;
  localparam int ITEM_TARGET = 1150;
  localparam int SETTLE      = 20;
  localparam int LIMIT_CYC   = 500000;

  typedef struct packed {
    logic          hit;
    logic [15:0]   id;
    logic [5:0]    slot;
    logic [AW-1:0] offset;
  } lookup_result_t;

  typedef enum int {FILL_SORTED, FILL_OVERLAP, FILL_DENSE, FILL_NOISE, FILL_GRID} fill_style_t;

  // Predicts lookup answers from its own copy of the range table and last-hit cache
  class section_map_model;
    logic [AW-1:0]  first_tab[SLOTS];
    logic [AW-1:0]  last_tab[SLOTS];
    logic [15:0]    id_tab[SLOTS];
    bit             present_tab[SLOTS];
    bit             cache_valid;
    int             cache_slot;
    int             entry_count;
    lookup_result_t expected_answers[$];
    int             errors;

    function new();
      foreach (present_tab[i]) present_tab[i] = 0;
      cache_valid = 0;
      cache_slot  = 0;
      entry_count = 0;
      errors      = 0;
    endfunction

    function bit covers(int s, logic [AW-1:0] a);
      return present_tab[s] && first_tab[s] <= a && a <= last_tab[s];
    endfunction

    function void set_count(logic [6:0] value);
      entry_count = value;
      cache_valid = 0;
    endfunction

    // Apply one accepted request; a lookup queues its answer
    function void take_request(logic act, logic [5:0] s, logic [AW-1:0] f,
                               logic [AW-1:0] l, logic [15:0] id, logic pres,
                               logic [AW-1:0] addr);
      lookup_result_t res;
      int lo, hi, mid, n, pos;
      bit found;
      if (act == arsl_pkg::ACT_WRITE) begin
        first_tab[s]   = f;
        last_tab[s]    = l;
        id_tab[s]      = id;
        present_tab[s] = pres;
        cache_valid    = 0;
      end else begin
        found = 0;
        pos   = 0;
        if (cache_valid && covers(cache_slot, addr)) begin
          found = 1;
          pos   = cache_slot;
        end else begin
          n  = entry_count > SLOTS ? SLOTS : entry_count;
          lo = 0;
          hi = n - 1;
          while (!found && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (covers(mid, addr)) begin
              found = 1;
              pos   = mid;
            end else if (addr < first_tab[mid]) begin
              hi = mid - 1;
            end else begin
              lo = mid + 1;
            end
          end
          if (found) begin
            cache_valid = 1;
            cache_slot  = pos;
          end
        end
        res.hit    = found;
        res.id     = found ? id_tab[pos] : 16'h0;
        res.slot   = found ? 6'(pos) : 6'h0;
        res.offset = found ? addr - first_tab[pos] : '0;
        expected_answers.push_back(res);
      end
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result against the oldest pending answer
    task compare_answer(lookup_result_t got);
      lookup_result_t exp;
      if (expected_answers.size() == 0) begin
        report("result with no lookup pending");
      end else begin
        exp = expected_answers.pop_front();
        if (got.hit !== exp.hit)
          report($sformatf("hit got %0b exp %0b", got.hit, exp.hit));
        if (got.id !== exp.id)
          report($sformatf("found_id got %0h exp %0h", got.id, exp.id));
        if (got.slot !== exp.slot)
          report($sformatf("found_slot got %0d exp %0d", got.slot, exp.slot));
        if (got.offset !== exp.offset)
          report($sformatf("offset got %0h exp %0h", got.offset, exp.offset));
      end
    endtask
  endclass

  logic          clk;
  logic          rst;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [6:0]    cfg_data;
  logic          in_valid;
  logic          in_ready;
  logic          action;
  logic [5:0]    slot;
  logic [AW-1:0] range_first;
  logic [AW-1:0] range_last;
  logic [15:0]   range_id;
  logic          range_present;
  logic [AW-1:0] query_addr;
  logic          out_valid;
  logic          out_ready;
  logic          hit;
  logic [15:0]   found_id;
  logic [5:0]    found_slot;
  logic [AW-1:0] offset;

  section_map_model model;
  int            items_done;
  bit            no_idle;
  logic [AW-1:0] last_query;

  address_range_section_lookup dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .slot          (slot),
    .range_first   (range_first),
    .range_last    (range_last),
    .range_id      (range_id),
    .range_present (range_present),
    .query_addr    (query_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .found_id      (found_id),
    .found_slot    (found_slot),
    .offset        (offset)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYC * 10);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [AW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [AW-1:0] grid_base(int i);
    return 64'(i) << 58;
  endfunction

  // Drive one request and hold it until accepted
  task automatic send(logic act, logic [5:0] s, logic [AW-1:0] f, logic [AW-1:0] l,
                      logic [15:0] id, logic pres, logic [AW-1:0] addr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    slot          <= s;
    range_first   <= f;
    range_last    <= l;
    range_id      <= id;
    range_present <= pres;
    query_addr    <= addr;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    model.take_request(act, s, f, l, id, pres, addr);
    items_done++;
  endtask

  task automatic write_slot(logic [5:0] s, logic [AW-1:0] f, logic [AW-1:0] l,
                            logic [15:0] id, logic pres);
    send(arsl_pkg::ACT_WRITE, s, f, l, id, pres, rand64());
  endtask

  task automatic lookup(logic [AW-1:0] addr);
    last_query = addr;
    send(arsl_pkg::ACT_LOOKUP, 6'($urandom), rand64(), rand64(), 16'($urandom),
         1'($urandom), addr);
  endtask

  // Drain all answers, let the block settle, then load entry_count
  task automatic set_entry_count(logic [6:0] value);
    in_valid <= 1'b0;
    while (model.expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    model.set_count(value);
    cfg_valid <= 1'b0;
  endtask

  // Load every slot with a table of the given shape
  task automatic fill_table(fill_style_t style);
    logic [AW-1:0] cursor, f, l, base;
    cursor = rand64() >> $urandom_range(8, 63);
    base   = $urandom_range(0, 1) ? '0 : 64'hFFFF_FFFF_FFFF_FFFF - 1023;
    for (int i = 0; i < SLOTS; i++) begin
      case (style)
        FILL_SORTED: begin
          f      = cursor + (rand64() >> $urandom_range(8, 63));
          l      = f + (rand64() >> $urandom_range(8, 63));
          cursor = l + 1;
        end
        FILL_OVERLAP: begin
          f      = cursor + (rand64() >> $urandom_range(10, 63));
          l      = f + (rand64() >> $urandom_range(8, 63));
          cursor = f + 1;
        end
        FILL_DENSE: begin
          f = base + 64'(i) * 16;
          l = f + 15;
        end
        FILL_GRID: begin
          f = grid_base(i);
          l = f + (64'd1 << 58) - 1;
        end
        default: begin
          f = rand64();
          l = rand64();
        end
      endcase
      if (style == FILL_GRID)
        write_slot(6'(i), f, l, 16'(i * 1031), !(i == 5 || i == 40));
      else
        write_slot(6'(i), f, l, 16'($urandom), $urandom_range(0, 9) != 0);
    end
  endtask

  // Aim mostly at range edges and interiors, with some noise and repeats
  function automatic logic [AW-1:0] pick_address();
    int k;
    logic [AW-1:0] f, l, span;
    k = $urandom_range(0, SLOTS - 1);
    f = model.first_tab[k];
    l = model.last_tab[k];
    case ($urandom_range(0, 9))
      0: return f;
      1: return l;
      2: return f - 1;
      3: return l + 1;
      4: return rand64();
      5: return last_query;
      6: return $urandom_range(0, 1) ? '0 : '1;
      default: begin
        if (l < f) return rand64();
        span = l - f + 1;
        if (span == 0) return rand64();
        return f + rand64() % span;
      end
    endcase
  endfunction

  task automatic random_write();
    int k;
    k = $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 2) != 0)
      write_slot(6'(k), model.first_tab[k], model.last_tab[k], 16'($urandom),
                 $urandom_range(0, 4) != 0);
    else
      write_slot(6'(k), rand64(), rand64(), 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Result side: stall at random, then take one result
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      model.compare_answer({hit, found_id, found_slot, offset});
    end
  end

  initial begin
    int phase;
    logic [6:0] count;
    model         = new();
    items_done    = 0;
    no_idle       = 0;
    last_query    = '0;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    action        <= arsl_pkg::ACT_WRITE;
    slot          <= '0;
    range_first   <= '0;
    range_last    <= '0;
    range_id      <= '0;
    range_present <= 1'b0;
    query_addr    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: evenly spaced table covering the whole address space
    fill_table(FILL_GRID);
    set_entry_count(7'd64);
    lookup('0);
    lookup('1);
    lookup('1);
    // absent slot steers the search but never matches
    lookup(grid_base(5) + 7);
    lookup(grid_base(11) - 1);
    lookup(grid_base(11));
    write_slot(6'd20, grid_base(20), grid_base(21) - 1, 16'hFFFF, 1'b1);
    lookup(grid_base(20) + 123);
    write_slot(6'd0, '0, '0, 16'h0000, 1'b1);
    lookup('0);
    lookup(64'd1);
    write_slot(6'd63, '1, '1, 16'h8001, 1'b1);
    lookup('1);
    set_entry_count(7'd1);
    lookup('0);
    lookup(grid_base(30));
    // count beyond the table size is clipped
    set_entry_count(7'd127);
    lookup(grid_base(62) + 5);
    set_entry_count(7'd0);
    lookup('0);
    lookup('1);

    // Random phases: new table shapes, counts and idle patterns
    phase = 0;
    while (items_done < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase % 3 == 0)
        fill_table(fill_style_t'($urandom_range(0, 3)));
      case (phase)
        0:       count = 7'd64;
        1:       count = 7'd127;
        2:       count = 7'd0;
        3:       count = 7'd1;
        4:       count = 7'd65;
        default: count = $urandom_range(0, 2) == 0 ? 7'd64 : 7'($urandom_range(0, 127));
      endcase
      set_entry_count(count);
      repeat (60) begin
        if ($urandom_range(0, 3) == 0)
          random_write();
        else
          lookup(pick_address());
      end
      phase++;
    end

    // Drain and finish
    in_valid <= 1'b0;
    while (model.expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (model.errors == 0 && model.expected_answers.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
